>>> src/bfea_pkg.sv
// Shared types and constants for the best-fit extent allocator.
package bfea_pkg;

  localparam logic [31:0] CEILING = 32'd20000000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND_RD,
    ST_FIND,
    ST_INS_SHIFT,
    ST_INS_PUT,
    ST_DEL_SHIFT,
    ST_MERGE_CHK,
    ST_SCAN,
    ST_SUM,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_FREE,
    OP_MERGE_DEL_NEW,
    OP_MERGE_INS,
    OP_MERGE_DEL_NEXT,
    OP_ALLOC_DEL,
    OP_ALLOC_INS,
    OP_FINISH
  } phase_t;

endpackage

>>> src/best_fit_extent_allocator_unit.sv
// Top level: sorted free-extent table with a sequencer for free and allocate requests.
//
// A request is taken when start is high and busy is low; busy stays high through the
// result strobe (done), which fires for one cycle, and the result must be captured then,
// since the receiver cannot hold it off. The table sits in a memory pair with one
// registered read and one write per cycle. Lookups and insert or removal shifts walk
// the table one entry per cycle; the allocate scan and the closing free-space sum spend
// a wait state on each entry's read before using it. Time grows with the number of
// entries held. No clearing pass is needed after reset.
module best_fit_extent_allocator_unit #(
  parameter int ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [31:0] req_offset,
  input  logic [31:0] req_size,
  output logic        done,
  output logic        granted,
  output logic [31:0] grant_offset,
  output logic        dropped,
  output logic [31:0] total_free
);
  import bfea_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] FULL = CW'(ENTRIES);

  logic [31:0] mem_s [ENTRIES];
  logic [31:0] mem_l [ENTRIES];

  state_t state, state_next;
  phase_t phase, phase_next;

  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] pos, pos_next;
  logic [31:0]   ks, ks_next, kl, kl_next;       // key for lookup/insert/erase
  logic          kins, kins_next;                // lookup is for insert
  logic [31:0]   sz, sz_next, off, off_next;
  logic [31:0]   ns, ns_next, nl, nl_next;
  logic [31:0]   best, best_next, bs, bs_next;
  logic          gr, gr_next, dr, dr_next;
  logic [31:0]   go, go_next, sum, sum_next;

  // read port: registered data
  logic [IW-1:0] raddr;
  logic [31:0]   rd_s, rd_l;
  // write port
  logic          we;
  logic [IW-1:0] waddr;
  logic [31:0]   wd_s, wd_l;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_s[waddr] <= wd_s;
      mem_l[waddr] <= wd_l;
    end
    rd_s <= mem_s[raddr];
    rd_l <= mem_l[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= OP_FINISH;
      count <= '0;
      sum   <= '0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      count <= count_next;
      sum   <= sum_next;
    end
    idx <= idx_next; pos <= pos_next; ks <= ks_next; kl <= kl_next;
    kins <= kins_next; sz <= sz_next; off <= off_next; ns <= ns_next;
    nl <= nl_next; best <= best_next; bs <= bs_next; gr <= gr_next;
    dr <= dr_next; go <= go_next;
  end

  logic less;
  assign less = (rd_s < ks) || (rd_s == ks && rd_l < kl);

  always_comb begin
    state_next = state; phase_next = phase; count_next = count; sum_next = sum;
    idx_next = idx; pos_next = pos; ks_next = ks; kl_next = kl; kins_next = kins;
    sz_next = sz; off_next = off; ns_next = ns; nl_next = nl; best_next = best;
    bs_next = bs; gr_next = gr; dr_next = dr; go_next = go;
    raddr = idx[IW-1:0];
    we = 1'b0; waddr = idx[IW-1:0]; wd_s = ks; wd_l = kl;
    busy = (state != ST_IDLE);
    done = 1'b0;

    case (state)
      ST_IDLE: begin
        if (start) begin
          sz_next = req_size; off_next = req_offset;
          gr_next = 1'b0; dr_next = 1'b0; go_next = '0;
          idx_next = '0;
          if (action) begin
            best_next = CEILING;
            state_next = ST_SCAN;
          end else begin
            ks_next = req_offset; kl_next = req_size; kins_next = 1'b1;
            phase_next = OP_FREE;
            state_next = ST_FIND_RD;
          end
        end
      end
      // lower-bound search: read entry idx, compare next cycle
      ST_FIND_RD: begin
        if (idx >= count) begin
          pos_next = idx; state_next = ST_FIND;
        end else begin
          state_next = ST_FIND;
        end
      end
      ST_FIND: begin
        if (idx < count && less) begin
          idx_next = idx + 1'b1;
          raddr = IW'(idx + 1'b1);
          if (idx + 1'b1 >= count) pos_next = idx + 1'b1;
        end else begin
          pos_next = idx;
          if (kins) begin
            if (idx < count && rd_s == ks && rd_l == kl) begin
              state_next = ST_MERGE_CHK;
              raddr = IW'(idx + 1'b1);
            end else if (count >= FULL) begin
              if (phase == OP_FREE) dr_next = 1'b1;
              phase_next = OP_FINISH;
              state_next = ST_MERGE_CHK;
            end else begin
              idx_next = count;
              state_next = (count == idx) ? ST_INS_PUT : ST_INS_SHIFT;
              raddr = IW'(count - 1'b1);
            end
          end else begin
            if (idx < count && rd_s == ks && rd_l == kl) begin
              idx_next = idx;
              raddr = IW'(idx + 1'b1);
              state_next = ST_DEL_SHIFT;
            end else begin
              state_next = ST_MERGE_CHK;
            end
          end
        end
      end
      // shift up: mem[idx] = mem[idx-1], descending to pos
      ST_INS_SHIFT: begin
        we = 1'b1; waddr = idx[IW-1:0]; wd_s = rd_s; wd_l = rd_l;
        idx_next = idx - 1'b1;
        raddr = IW'(idx - 2'd2);
        if (idx - 1'b1 == pos) state_next = ST_INS_PUT;
      end
      ST_INS_PUT: begin
        we = 1'b1; waddr = pos[IW-1:0]; wd_s = ks; wd_l = kl;
        count_next = count + 1'b1;
        raddr = IW'(pos + 1'b1);
        state_next = ST_MERGE_CHK;
      end
      // shift down: mem[idx] = mem[idx+1]
      ST_DEL_SHIFT: begin
        if (idx + 1'b1 >= count) begin
          count_next = count - 1'b1;
          state_next = ST_MERGE_CHK;
        end else begin
          we = 1'b1; waddr = idx[IW-1:0]; wd_s = rd_s; wd_l = rd_l;
          idx_next = idx + 1'b1;
          raddr = IW'(idx + 2'd2);
        end
      end
      // rd holds mem[pos+1] when a free-phase insert or hit arrives here
      ST_MERGE_CHK: begin
        idx_next = '0;
        state_next = ST_FIND_RD;
        case (phase)
          OP_FREE: begin
            if (!dr && pos + 1'b1 < count && rd_s == off + sz) begin
              ns_next = rd_s; nl_next = rd_l;
              ks_next = off; kl_next = sz; kins_next = 1'b0;
              phase_next = OP_MERGE_DEL_NEW;
            end else begin
              state_next = ST_SUM; sum_next = '0;
            end
          end
          OP_MERGE_DEL_NEW: begin
            ks_next = off; kl_next = sz + nl; kins_next = 1'b1;
            phase_next = OP_MERGE_INS;
          end
          OP_MERGE_INS: begin
            ks_next = ns; kl_next = nl; kins_next = 1'b0;
            phase_next = OP_MERGE_DEL_NEXT;
          end
          OP_ALLOC_DEL: begin
            ks_next = bs + sz; kl_next = best - sz; kins_next = 1'b1;
            phase_next = OP_ALLOC_INS;
          end
          default: begin
            state_next = ST_SUM; sum_next = '0;
          end
        endcase
      end
      // allocate scan: rd is valid in the cycle after raddr; idx tracks the pending read
      ST_SCAN: begin
        if (idx >= count) begin
          if (best != CEILING) begin
            gr_next = 1'b1; go_next = bs;
            ks_next = bs; kl_next = best; kins_next = 1'b0;
            phase_next = OP_ALLOC_DEL; idx_next = '0;
            state_next = ST_FIND_RD;
          end else begin
            sum_next = '0; state_next = ST_SUM;
          end
        end else begin
          state_next = ST_SCAN;
          // kins serves as the read-pending flag here
          if (!kins) begin
            kins_next = 1'b1;
          end else begin
            kins_next = 1'b0;
            if (rd_l == sz) begin
              gr_next = 1'b1; go_next = rd_s;
              ks_next = rd_s; kl_next = rd_l; kins_next = 1'b0;
              phase_next = OP_FINISH;
              raddr = IW'(idx + 1'b1);
              state_next = ST_DEL_SHIFT;
            end else begin
              if (rd_l > sz && rd_l < best) begin
                best_next = rd_l; bs_next = rd_s;
              end
              idx_next = idx + 1'b1;
            end
          end
        end
      end
      ST_SUM: begin
        if (idx >= count) begin
          state_next = ST_DONE;
        end else if (!kins) begin
          kins_next = 1'b1;
        end else begin
          kins_next = 1'b0;
          sum_next = sum + rd_l;
          idx_next = idx + 1'b1;
          raddr = IW'(idx + 1'b1);
        end
      end
      ST_DONE: begin
        done = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase

    // scan and sum start with the read-pending flag clear
    if (state != ST_SCAN && state_next == ST_SCAN) kins_next = 1'b0;
    if (state != ST_SUM && state_next == ST_SUM) begin
      kins_next = 1'b0; idx_next = '0;
    end
  end

  assign granted      = gr;
  assign grant_offset = go;
  assign dropped      = dr;
  assign total_free   = sum;

endmodule
